FILE: rtl/icv_pkg.sv
package icv_pkg;

   // crc-64-we constants
   localparam logic [63:0] CRC_POLY = 64'h42F0_E1EB_A9EA_3693;
   localparam logic [63:0] CRC_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam int unsigned POS_WIDTH = 30;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_CRC_SLOT     = 1'b0,
      CSR_EXPECTED_CRC = 1'b1
   } csr_index_type;

   // input transaction payload
   typedef struct packed {
      logic [31:0] word_data;
      logic        read_ok;
      logic        last_word;
   } icv_req_type;

   // result transaction payload
   typedef struct packed {
      logic [63:0] crc_value;
      logic        crc_matches;
   } icv_rsp_type;

   // configuration seen by the datapath
   typedef struct packed {
      logic [POS_WIDTH-1:0] crc_slot_word_index;
      logic [63:0]          expected_crc;
   } icv_cfg_type;

   // columns of the 32-bit msb-first update: effect of bit i of the top half
   function automatic logic [31:0][63:0] crc_cols_gen();
      logic [31:0][63:0] cols;
      logic [63:0]       c;
      for (int i = 0; i < 32; i++) begin
         c = 64'(1) << (32 + i);
         for (int k = 0; k < 32; k++) begin
            c = c[63] ? ((c << 1) ^ CRC_POLY) : (c << 1);
         end
         cols[i] = c;
      end
      return cols;
   endfunction

   localparam logic [31:0][63:0] CRC_COLS = crc_cols_gen();

   // fold 32 message bits (bit 31 first) into the crc
   function automatic logic [63:0] crc_fold32(input logic [63:0] crc, input logic [31:0] msg);
      logic [63:0] acc;
      logic [31:0] h;
      h   = crc[63:32] ^ msg;
      acc = {crc[31:0], 32'b0};
      for (int i = 0; i < 32; i++) begin
         acc = acc ^ ({64{h[i]}} & CRC_COLS[i]);
      end
      return acc;
   endfunction

endpackage

FILE: rtl/icv_fold.sv
module icv_fold
   import icv_pkg::*;
(
   input  logic [63:0]          crc_cur,
   input  icv_req_type          item,
   input  logic [POS_WIDTH-1:0] word_pos,
   input  logic [POS_WIDTH-1:0] slot_index,
   output logic [63:0]          crc_nxt
);

   logic [POS_WIDTH-1:0] slot_second;
   logic                 in_slot;
   logic [31:0]          msg;

   // the two slot words, second one wraps at the top index
   assign slot_second = slot_index + POS_WIDTH'(1);
   assign in_slot     = (word_pos == slot_index) || (word_pos == slot_second);

   // lowest-address byte goes first, each byte msb first
   assign msg = in_slot ? 32'b0
                        : {item.word_data[7:0], item.word_data[15:8],
                           item.word_data[23:16], item.word_data[31:24]};

   // slot words fold as zeros, failed reads are skipped
   always_comb begin
      if (in_slot || item.read_ok) begin
         crc_nxt = crc_fold32(crc_cur, msg);
      end else begin
         crc_nxt = crc_cur;
      end
   end

endmodule

FILE: rtl/icv_core.sv
module icv_core
   import icv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  icv_cfg_type cfg,
   input  logic        req_valid,
   output logic        req_stall,
   input  icv_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output icv_rsp_type rsp_data
);

   logic                 stage_valid_ff;
   icv_req_type          stage_ff;
   logic [63:0]          crc_ff;
   logic [POS_WIDTH-1:0] pos_ff;
   logic                 out_valid_ff;
   icv_rsp_type          out_ff;

   logic                 out_free;
   logic                 advance;
   logic                 req_take;
   logic [63:0]          crc_in;
   logic [63:0]          fin;

   // handshake: a last word needs room in the output register
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = stage_valid_ff && (!stage_ff.last_word || out_free);
   assign req_stall = stage_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   icv_fold u_fold (
      .crc_cur    (crc_ff),
      .item       (stage_ff),
      .word_pos   (pos_ff),
      .slot_index (cfg.crc_slot_word_index),
      .crc_nxt    (crc_in)
   );

   assign fin = crc_in ^ CRC_ONES;

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_take) begin
         stage_valid_ff <= 1'b1;
      end else if (advance) begin
         stage_valid_ff <= 1'b0;
      end
      if (req_take) begin
         stage_ff <= req_data;
      end
   end

   // running crc and word position
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_ONES;
         pos_ff <= '0;
      end else if (advance) begin
         if (stage_ff.last_word) begin
            crc_ff <= CRC_ONES;
            pos_ff <= '0;
         end else begin
            crc_ff <= crc_in;
            pos_ff <= pos_ff + POS_WIDTH'(1);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && stage_ff.last_word) begin
         out_valid_ff <= 1'b1;
      end else if (out_free) begin
         out_valid_ff <= 1'b0;
      end
      if (advance && stage_ff.last_word) begin
         out_ff.crc_value   <= fin;
         out_ff.crc_matches <= (fin == cfg.expected_crc);
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

FILE: rtl/image_crc64_verifier_top.sv
// image crc-64-we verifier
// req channel: one 32-bit storage word per transaction, lowest-address byte
//   in bits 7:0, with read_ok and last_word flags; accepted when req_valid
//   is high and req_stall is low
// rsp channel: one transaction per image, on the word flagged last_word,
//   carrying the final crc and the compare against expected_crc
// csr channel: csr_index 0 writes the crc slot word index, 1 the expected
//   crc; csr_ready is always high, write only while the block is idle
// throughput: one word per cycle while req_stall is low, set by the 32-bit
//   combinational crc update between input stage and running crc registers
// result path: input stage register, then output register, then rsp
// reset: running crc returns to all ones, word position and both csr
//   registers to zero, no transaction is held
// rsp stall: the result holds in the output register; words keep flowing
//   until a second last word reaches the input stage, then req_stall rises
module image_crc64_verifier_top
   import icv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  icv_req_type   req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output icv_rsp_type   rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [63:0]   csr_data
);

   logic [POS_WIDTH-1:0] slot_ff;
   logic [63:0]          expected_ff;
   icv_cfg_type          cfg;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff     <= '0;
         expected_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CRC_SLOT:     slot_ff     <= csr_data[POS_WIDTH-1:0];
            CSR_EXPECTED_CRC: expected_ff <= csr_data;
            default:          slot_ff     <= slot_ff;
         endcase
      end
   end

   assign cfg.crc_slot_word_index = slot_ff;
   assign cfg.expected_crc        = expected_ff;

   icv_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/icv_checker.sv
module icv_checker
   import icv_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_stall,
   input icv_req_type   req_data,
   input logic          rsp_valid,
   input logic          rsp_stall,
   input icv_rsp_type   rsp_data,
   input logic          csr_valid,
   input logic          csr_ready,
   input csr_index_type csr_index,
   input logic [63:0]   csr_data
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transaction changed while stalled");

   // reset leaves no result and no back-pressure
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("state not cleared by reset");

   // the input only stalls behind a pending result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without a blocked result");

   // the configuration port never back-pressures
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("csr write refused");

endmodule

bind image_crc64_verifier_top icv_checker u_icv_checker (.*);
